// ===== sv/hia_pkg.sv =====
// hia_pkg: field widths and operation codes for the handle id allocator
// no dependencies; used by handle_id_allocator_core and the testbench
package hia_pkg;

	localparam int HANDLE_W = 32;
	localparam int ENTRY_W  = 32;
	localparam int BASE_W   = 31;
	localparam int OP_W     = 2;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_ALLOC   = 2'd0;
	localparam op_t OP_RELEASE = 2'd1;
	localparam op_t OP_LOOKUP  = 2'd2;

	// handle given back when no index is free
	localparam logic [HANDLE_W-1:0] HANDLE_NONE = '1;

endpackage

// ===== sv/hia_ram.sv =====
// hia_ram: single write port, single read port memory with registered read data
// uses no package; instantiated by handle_id_allocator_core for stack and table
module hia_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/handle_id_allocator_core.sv =====
// handle_id_allocator_core: free-index stack allocator with an entry table
// depends on hia_pkg and hia_ram (free stack memory and entry table memory)
// a result strobes on done, registered from the write-back state entered on the start transfer
// each request takes the memory read then the write-back; busy blocks a new request during the write-back
// reset: busy stays high while a clearing pass refills the stack
// and zeroes the table; cfg writes are taken at any time; the receiver cannot stall
module handle_id_allocator_core #(
	parameter int ID_COUNT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hia_pkg::BASE_W-1:0]    cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic [hia_pkg::OP_W-1:0]      op,
	input  logic [hia_pkg::ENTRY_W-1:0]   entry_value,
	input  logic [hia_pkg::HANDLE_W-1:0]  handle_in,
	output logic                          done,
	output logic                          ok,
	output logic [hia_pkg::HANDLE_W-1:0]  handle_out,
	output logic [hia_pkg::ENTRY_W-1:0]   entry_out
);

	localparam int IDX_W = $clog2(ID_COUNT);
	localparam int TOP_W = $clog2(ID_COUNT + 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WB    = 2'd2;

	logic [1:0]                    state_q;
	logic [IDX_W-1:0]              clr_q;
	logic [TOP_W-1:0]              top_q;
	logic [hia_pkg::BASE_W-1:0]    base_q;

	hia_pkg::op_t                  op_s1;
	logic [hia_pkg::ENTRY_W-1:0]   entry_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic                          inrange_s1;

	logic                          done_q;
	logic                          ok_q;
	logic [hia_pkg::HANDLE_W-1:0]  handle_out_q;
	logic [hia_pkg::ENTRY_W-1:0]   entry_out_q;

	logic                          accept;
	logic [hia_pkg::HANDLE_W-1:0]  base_ext;
	logic [hia_pkg::HANDLE_W-1:0]  hi_bound;
	logic [hia_pkg::HANDLE_W-1:0]  diff;
	logic                          inrange;
	logic [TOP_W-1:0]              top_m1;
	logic                          empty;
	logic                          full;

	logic                          stk_we;
	logic [IDX_W-1:0]              stk_waddr;
	logic [IDX_W-1:0]              stk_wdata;
	logic [IDX_W-1:0]              stk_rdata;
	logic                          tbl_we;
	logic [IDX_W-1:0]              tbl_waddr;
	logic [hia_pkg::ENTRY_W-1:0]   tbl_wdata;
	logic [hia_pkg::ENTRY_W-1:0]   tbl_rdata;

	logic                          res_ok;
	logic [hia_pkg::HANDLE_W-1:0]  res_handle;
	logic [hia_pkg::ENTRY_W-1:0]   res_entry;
	logic [TOP_W-1:0]              top_next;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// range check on the full sum; base + ID_COUNT stays below 2^32
	assign base_ext = {1'b0, base_q};
	assign hi_bound = base_ext + hia_pkg::HANDLE_W'(ID_COUNT);
	assign diff     = handle_in - base_ext;
	assign inrange  = (handle_in != hia_pkg::HANDLE_NONE) && (handle_in >= base_ext)
		&& (handle_in < hi_bound);

	assign top_m1 = top_q - TOP_W'(1);
	assign empty  = (top_q == '0);
	assign full   = (top_q == TOP_W'(ID_COUNT));

	hia_ram #(.DEPTH(ID_COUNT), .WIDTH(IDX_W)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (accept),
		.raddr (top_m1[IDX_W-1:0]),
		.rdata (stk_rdata)
	);

	hia_ram #(.DEPTH(ID_COUNT), .WIDTH(hia_pkg::ENTRY_W)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (accept),
		.raddr (diff[IDX_W-1:0]),
		.rdata (tbl_rdata)
	);

	// write-back stage, where memory read data is valid, and the clearing pass writes
	always_comb begin
		stk_we     = 1'b0;
		stk_waddr  = top_q[IDX_W-1:0];
		stk_wdata  = idx_s1;
		tbl_we     = 1'b0;
		tbl_waddr  = idx_s1;
		tbl_wdata  = '0;
		res_ok     = 1'b0;
		res_handle = '0;
		res_entry  = '0;
		top_next   = top_q;
		unique case (state_q)
			ST_CLEAR: begin
				stk_we    = 1'b1;
				stk_waddr = clr_q;
				stk_wdata = clr_q;
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
			end
			ST_WB: begin
				unique case (op_s1)
					hia_pkg::OP_ALLOC: begin
						res_handle = hia_pkg::HANDLE_NONE;
						if (!empty) begin
							top_next   = top_m1;
							tbl_we     = 1'b1;
							tbl_waddr  = stk_rdata;
							tbl_wdata  = entry_s1;
							res_ok     = 1'b1;
							res_handle = base_ext + hia_pkg::HANDLE_W'(stk_rdata);
						end
					end
					hia_pkg::OP_RELEASE: begin
						if (inrange_s1) begin
							res_ok = 1'b1;
							tbl_we = 1'b1;
							// push is dropped on a full stack, slot still cleared
							if (!full) begin
								stk_we   = 1'b1;
								top_next = top_q + TOP_W'(1);
							end
						end
					end
					hia_pkg::OP_LOOKUP: begin
						if (inrange_s1) begin
							res_ok    = 1'b1;
							res_entry = tbl_rdata;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			top_q   <= TOP_W'(ID_COUNT);
			base_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			top_q  <= top_next;
			done_q <= (state_q == ST_WB);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(ID_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op;
			entry_s1   <= entry_value;
			idx_s1     <= diff[IDX_W-1:0];
			inrange_s1 <= inrange;
		end
		if (state_q == ST_WB) begin
			ok_q         <= res_ok;
			handle_out_q <= res_handle;
			entry_out_q  <= res_entry;
		end
	end

	assign done       = done_q;
	assign ok         = ok_q;
	assign handle_out = handle_out_q;
	assign entry_out  = entry_out_q;

`ifndef SYNTH
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted item gave no result");

	a_done_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_WB)
		else $error("result strobe without write-back");

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_W'(ID_COUNT))
		else $error("stack top beyond capacity");

	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB && op_s1 == hia_pkg::OP_ALLOC && top_q != '0)
		|=> top_q == $past(top_q) - TOP_W'(1))
		else $error("allocate did not pop the stack");

	a_alloc_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(done && handle_out != '0) |-> entry_out == '0)
		else $error("allocate result carries an entry word");
`endif

endmodule

// ===== tb/handle_id_allocator_checker.sv =====
// handle_id_allocator_checker: watches the request, result and cfg ports of the allocator,
// keeps its own free stack, entry table and handle base, and compares every result
// depends on hia_pkg
module handle_id_allocator_checker #(
	parameter int ID_COUNT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hia_pkg::BASE_W-1:0]    cfg_wdata,
	input  logic                          start,
	input  logic                          busy,
	input  logic [hia_pkg::OP_W-1:0]      op,
	input  logic [hia_pkg::ENTRY_W-1:0]   entry_value,
	input  logic [hia_pkg::HANDLE_W-1:0]  handle_in,
	input  logic                          done,
	input  logic                          ok,
	input  logic [hia_pkg::HANDLE_W-1:0]  handle_out,
	input  logic [hia_pkg::ENTRY_W-1:0]   entry_out,
	output int                            mismatch_count,
	output int                            outstanding
);

	localparam int IDX_W = $clog2(ID_COUNT);

	typedef struct packed {
		logic                         ok;
		logic [hia_pkg::HANDLE_W-1:0] handle;
		logic [hia_pkg::ENTRY_W-1:0]  entry;
	} reply_t;

	logic [IDX_W-1:0]            free_idx [ID_COUNT];
	logic [hia_pkg::ENTRY_W-1:0] entry_mem [ID_COUNT];
	int unsigned                 free_top;
	logic [hia_pkg::BASE_W-1:0]  base_reg;
	reply_t                      due_replies [$];

	// full 33-bit compare, the upper bound never wraps
	function automatic logic handle_hit(input logic [hia_pkg::HANDLE_W-1:0] h,
			output logic [IDX_W-1:0] idx);
		logic [hia_pkg::HANDLE_W:0] lo;
		logic [hia_pkg::HANDLE_W:0] hi;
		logic [hia_pkg::HANDLE_W:0] hh;
		lo = {2'b00, base_reg};
		hi = lo + ID_COUNT;
		hh = {1'b0, h};
		idx = IDX_W'(hh - lo);
		return (h != hia_pkg::HANDLE_NONE) && (hh >= lo) && (hh < hi);
	endfunction

	function automatic reply_t serve_request(input hia_pkg::op_t o,
			input logic [hia_pkg::ENTRY_W-1:0] ev,
			input logic [hia_pkg::HANDLE_W-1:0] h);
		reply_t r;
		logic [IDX_W-1:0] idx;
		r = '0;
		case (o)
		hia_pkg::OP_ALLOC: begin
			r.handle = hia_pkg::HANDLE_NONE;
			if (free_top > 0) begin
				free_top--;
				idx = free_idx[free_top];
				entry_mem[idx] = ev;
				r.handle = {1'b0, base_reg} + hia_pkg::HANDLE_W'(idx);
				r.ok = 1'b1;
			end
		end
		hia_pkg::OP_RELEASE: begin
			if (handle_hit(h, idx)) begin
				r.ok = 1'b1;
				// push onto a full stack is dropped, the slot is cleared anyway
				if (free_top < ID_COUNT) begin
					free_idx[free_top] = idx;
					free_top++;
				end
				entry_mem[idx] = '0;
			end
		end
		hia_pkg::OP_LOOKUP: begin
			if (handle_hit(h, idx)) begin
				r.ok = 1'b1;
				r.entry = entry_mem[idx];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("checker: %s got %h want %h at %0t", field, got, want, $time);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < ID_COUNT; i++) begin
				free_idx[i] = IDX_W'(i);
				entry_mem[i] = '0;
			end
			free_top = ID_COUNT;
			base_reg = '0;
			due_replies.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (due_replies.size() == 0) begin
					note_mismatch("result with nothing pending, handle_out", handle_out, '0);
				end else begin
					want = due_replies.pop_front();
					if (ok !== want.ok)
						note_mismatch("ok", 32'(ok), 32'(want.ok));
					if (handle_out !== want.handle)
						note_mismatch("handle_out", handle_out, want.handle);
					if (entry_out !== want.entry)
						note_mismatch("entry_out", entry_out, want.entry);
				end
			end
			if (cfg_we)
				base_reg = cfg_wdata;
			// request transfer
			if (start && !busy)
				due_replies.push_back(serve_request(op, entry_value, handle_in));
			outstanding <= due_replies.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for handle_id_allocator_core
// depends on hia_pkg, handle_id_allocator_core and handle_id_allocator_checker
module tb;

	localparam int ID_COUNT    = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam hia_pkg::op_t OP_UNUSED = 2'd3;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [hia_pkg::BASE_W-1:0]   cfg_wdata;
	logic                         start;
	logic                         busy;
	hia_pkg::op_t                 op;
	logic [hia_pkg::ENTRY_W-1:0]  entry_value;
	logic [hia_pkg::HANDLE_W-1:0] handle_in;
	logic                         done;
	logic                         ok;
	logic [hia_pkg::HANDLE_W-1:0] handle_out;
	logic [hia_pkg::ENTRY_W-1:0]  entry_out;

	int                           mismatch_count;
	int                           outstanding;
	int                           idle_pct;
	logic [hia_pkg::BASE_W-1:0]   base_now;
	int unsigned                  cycle_count;

	handle_id_allocator_core #(
		.ID_COUNT(ID_COUNT)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.entry_value(entry_value),
		.handle_in  (handle_in),
		.done       (done),
		.ok         (ok),
		.handle_out (handle_out),
		.entry_out  (entry_out)
	);

	handle_id_allocator_checker #(
		.ID_COUNT(ID_COUNT)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.entry_value   (entry_value),
		.handle_in     (handle_in),
		.done          (done),
		.ok            (ok),
		.handle_out    (handle_out),
		.entry_out     (entry_out),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// handle relative to the current base: mostly in range, often at the edges
	function automatic logic [hia_pkg::HANDLE_W-1:0] pick_handle();
		logic [hia_pkg::HANDLE_W-1:0] b;
		b = {1'b0, base_now};
		case ($urandom_range(11))
		0: return hia_pkg::HANDLE_NONE;
		1: return $urandom();
		2: return b - 1;
		3: return b + ID_COUNT;
		4: return b + ID_COUNT - 1;
		5: return b;
		default: return b + $urandom_range(ID_COUNT - 1);
		endcase
	endfunction

	function automatic logic [hia_pkg::ENTRY_W-1:0] pick_entry();
		case ($urandom_range(7))
		0: return '0;
		1: return '1;
		default: return $urandom();
		endcase
	endfunction

	// holds the request until the transfer, then idles at random
	task automatic send_request(input hia_pkg::op_t o, input logic [hia_pkg::ENTRY_W-1:0] ev,
			input logic [hia_pkg::HANDLE_W-1:0] h);
		start <= 1'b1;
		op <= o;
		entry_value <= ev;
		handle_in <= h;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			op <= hia_pkg::op_t'($urandom());
			entry_value <= $urandom();
			handle_in <= $urandom();
			@(posedge clk);
		end
	endtask

	// base changes only once every pending result has come back
	task automatic set_base(input logic [hia_pkg::BASE_W-1:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		base_now = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_requests(input int count, input int alloc_pct);
		int r;
		hia_pkg::op_t o;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < alloc_pct)
				o = hia_pkg::OP_ALLOC;
			else if (r < alloc_pct + (95 - alloc_pct) / 2)
				o = hia_pkg::OP_RELEASE;
			else if (r < 95)
				o = hia_pkg::OP_LOOKUP;
			else
				o = OP_UNUSED;
			send_request(o, pick_entry(), pick_handle());
		end
	endtask

	initial begin
		int phase_idle [4];
		int phase_alloc [4];
		logic [hia_pkg::BASE_W-1:0] phase_base [4];

		phase_idle = '{0, 88, 0, 24};
		phase_alloc = '{40, 45, 15, 55};
		phase_base = '{hia_pkg::BASE_W'($urandom()), '1, '0,
			hia_pkg::BASE_W'($urandom_range(4096))};

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		start <= 1'b0;
		op <= hia_pkg::OP_ALLOC;
		entry_value <= '0;
		handle_in <= '0;
		idle_pct = 0;
		base_now = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// clearing pass after reset
		while (busy)
			@(posedge clk);

		// zero base, stack full
		set_base('0);
		send_request(hia_pkg::OP_LOOKUP, '0, '0);
		send_request(hia_pkg::OP_RELEASE, '0, '0);
		send_request(hia_pkg::OP_LOOKUP, '0, hia_pkg::HANDLE_NONE);
		send_request(hia_pkg::OP_LOOKUP, '0, ID_COUNT);
		send_request(hia_pkg::OP_ALLOC, '1, '0);
		send_request(hia_pkg::OP_ALLOC, '0, '1);
		send_request(hia_pkg::OP_LOOKUP, '0, ID_COUNT - 1);
		send_request(hia_pkg::OP_LOOKUP, '0, ID_COUNT - 2);
		send_request(hia_pkg::OP_RELEASE, '0, ID_COUNT - 1);
		send_request(hia_pkg::OP_RELEASE, '0, ID_COUNT - 1);
		send_request(hia_pkg::OP_ALLOC, 32'h5A5A_A5A5, '0);
		send_request(hia_pkg::OP_LOOKUP, '0, ID_COUNT - 1);
		send_request(OP_UNUSED, '1, '1);
		send_request(hia_pkg::OP_RELEASE, '0, ID_COUNT);
		send_request(hia_pkg::OP_RELEASE, '0, hia_pkg::HANDLE_NONE);

		// largest base, handles cross into the top bit
		set_base('1);
		send_request(hia_pkg::OP_ALLOC, 32'hC3C3_3C3C, '0);
		send_request(hia_pkg::OP_LOOKUP, '0, {1'b0, base_now} + ID_COUNT - 1);
		send_request(hia_pkg::OP_LOOKUP, '0, {1'b0, base_now} + ID_COUNT);
		send_request(hia_pkg::OP_LOOKUP, '0, {1'b0, base_now} - 1);
		send_request(hia_pkg::OP_RELEASE, '0, {1'b0, base_now} + ID_COUNT - 1);
		send_request(hia_pkg::OP_LOOKUP, '0, {1'b0, base_now});

		for (int p = 0; p < 4; p++) begin
			set_base(phase_base[p]);
			idle_pct = phase_idle[p];
			random_requests(120, phase_alloc[p]);
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
